>>> sv/lpcm_su_pkg.sv
// ----------------------------------------------------------------------------
// lpcm_su_pkg
// Shared types and constants for the LPCM sample unpacker.
// ----------------------------------------------------------------------------
`default_nettype none

package lpcm_su_pkg;

    localparam int MAX_CHANNELS_DEF = 8;
    localparam int POS_W            = 6;
    localparam int CHAN_W           = 3;
    localparam int SAMPLE_W         = 24;
    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;

    // register indexes, byte address is 4 * index
    localparam logic REG_WIDTH_MODE = 1'b0;
    localparam logic REG_CHAN_M1    = 1'b1;

    typedef enum logic [1:0] {
        MODE_16  = 2'd0,
        MODE_20  = 2'd1,
        MODE_24  = 2'd2,
        MODE_16B = 2'd3
    } t_width_mode;

    // what a byte does once it reaches the assembly stage
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_S16  = 2'd1,
        KIND_S24  = 2'd2,
        KIND_S20  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_value;
        logic [CHAN_W-1:0]          channel_index;
        logic                       last_of_run;
    } t_out;

endpackage

`default_nettype wire

>>> sv/lpcm_sample_unpacker.sv
// ----------------------------------------------------------------------------
// lpcm_sample_unpacker
// Unpacks DVD LPCM frame payload bytes into Q0.23 samples with channel number.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                   payload
// input     in         i_in_valid / o_in_ready     i_in_item  (t_in)
// output    out        o_out_valid / i_out_ready   o_out_item (t_out)
// config    in         psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// a byte is accepted every cycle while the output keeps up; a 20-bit trailing
// byte makes two samples that leave through the result register one per
// cycle while the output is ready, so the assembly stage waits for both. a
// byte is registered in the buffer read and assembly stage, then in the
// result register, before its first sample shows. reset clears chunk
// position, registers and valid flags; the high-byte buffer is not cleared.
// a stalled output holds the assembly stage and the input side stops only once both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcm_sample_unpacker #(
    parameter int MAX_CHANNELS = lpcm_su_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire lpcm_su_pkg::t_in                    i_in_item,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output lpcm_su_pkg::t_out                        o_out_item,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lpcm_su_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [lpcm_su_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [lpcm_su_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                     pready
);

    import lpcm_su_pkg::*;

    localparam int BANK_DEPTH = 2 * MAX_CHANNELS;
    localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam logic [3:0] MaxCh = 4'(MAX_CHANNELS);

    // configuration
    t_width_mode       r_mode;
    logic [CHAN_W-1:0] r_chan_m1;
    logic              cfg_wr;

    // position and front end
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    logic [3:0]        num_ch;
    logic [POS_W-1:0]  chunk_len;
    logic [POS_W-1:0]  four_n;
    logic [POS_W-1:0]  p;
    logic [POS_W-1:0]  p_inc;
    logic [POS_W-1:0]  j;
    logic [POS_W-1:0]  k0;
    logic [POS_W-1:0]  k1;
    logic [POS_W-1:0]  n_wide;
    t_kind             kind;
    logic              store_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr_a;
    logic [AW-1:0]     rd_addr_b;
    logic [CHAN_W-1:0] ch0;
    logic [CHAN_W-1:0] ch1;
    logic              accept;

    // buffer banks: even and odd high bytes
    logic [7:0]        ev_a, ev_b, od_a, od_b;

    // assembly stage
    logic              r_s1_valid;
    t_kind             r_s1_kind;
    logic [7:0]        r_s1_byte;
    logic [CHAN_W-1:0] r_s1_ch0;
    logic [CHAN_W-1:0] r_s1_ch1;
    logic              s1_adv;
    t_out              res0;
    t_out              res1;

    // result register, second sample of a 20-bit pair waits in r_o1
    logic              r_ov;
    logic              r_two;
    t_out              r_o0;
    t_out              r_o1;
    logic              pair_free;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            REG_WIDTH_MODE: prdata = {{(APB_DATA_W-2){1'b0}}, r_mode};
            REG_CHAN_M1:    prdata = {{(APB_DATA_W-CHAN_W){1'b0}}, r_chan_m1};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_16;
            r_chan_m1 <= CHAN_W'(1);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_WIDTH_MODE: r_mode    <= t_width_mode'(pwdata[1:0]);
                REG_CHAN_M1:    r_chan_m1 <= pwdata[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- front end: position and buffer access ----------------
    always_comb begin
        num_ch = {1'b0, r_chan_m1} + 4'd1;
        if (num_ch > MaxCh) begin
            num_ch = MaxCh;
        end
        n_wide = {2'b00, num_ch};
        four_n = {num_ch, 2'b00};

        case (r_mode) inside
            MODE_20: chunk_len = four_n + n_wide;
            MODE_24: chunk_len = four_n + {1'b0, num_ch, 1'b0};
            default: chunk_len = {1'b0, num_ch, 1'b0};
        endcase

        // realign on frame start or when the registers moved the chunk
        p     = (i_in_item.frame_start || r_pos >= chunk_len) ? '0 : r_pos;
        p_inc = p + POS_W'(1);
        n_pos = (p_inc >= chunk_len) ? '0 : p_inc;

        j  = p - four_n;
        k0 = {j[POS_W-2:0], 1'b0};
        k1 = {j[POS_W-2:0], 1'b1};

        kind      = KIND_NONE;
        store_en  = 1'b0;
        wr_addr   = p[AW:1];
        rd_addr_a = '0;
        rd_addr_b = '0;
        ch0       = '0;
        ch1       = '0;

        case (r_mode) inside
            MODE_16, MODE_16B: begin
                if (p[0]) begin
                    kind = KIND_S16;
                    ch0  = p[CHAN_W:1];
                end else begin
                    store_en = 1'b1;
                    wr_addr  = '0;
                end
            end
            default: begin
                if (p < four_n) begin
                    store_en = 1'b1;
                end else if (r_mode == MODE_24) begin
                    kind      = KIND_S24;
                    rd_addr_a = j[AW-1:0];
                    ch0       = (j >= n_wide) ? CHAN_W'(j - n_wide) : j[CHAN_W-1:0];
                end else begin
                    kind      = KIND_S20;
                    rd_addr_a = k0[AW-1:0];
                    rd_addr_b = k1[AW-1:0];
                    ch0       = (k0 >= n_wide) ? CHAN_W'(k0 - n_wide) : k0[CHAN_W-1:0];
                    ch1       = (k1 >= n_wide) ? CHAN_W'(k1 - n_wide) : k1[CHAN_W-1:0];
                end
            end
        endcase
    end

    assign pair_free  = !r_ov || (i_out_ready && !r_two);
    assign s1_adv     = r_s1_valid && ((r_s1_kind == KIND_NONE) || pair_free);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign accept     = i_in_valid && o_in_ready;

    // in 16-bit mode the stored byte always lands at buffer entry zero
    lpcm_su_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_even (
        .i_clk     (i_clk),
        .i_we      (accept && store_en && !p[0]),
        .i_waddr   (wr_addr),
        .i_wdata   (i_in_item.data_byte),
        .i_re      (accept),
        .i_raddr_a (rd_addr_a),
        .i_raddr_b (rd_addr_b),
        .o_rdata_a (ev_a),
        .o_rdata_b (ev_b)
    );

    lpcm_su_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_odd (
        .i_clk     (i_clk),
        .i_we      (accept && store_en && p[0]),
        .i_waddr   (wr_addr),
        .i_wdata   (i_in_item.data_byte),
        .i_re      (accept),
        .i_raddr_a (rd_addr_a),
        .i_raddr_b (rd_addr_b),
        .o_rdata_a (od_a),
        .o_rdata_b (od_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pos <= n_pos;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind <= kind;
            r_s1_byte <= i_in_item.data_byte;
            r_s1_ch0  <= ch0;
            r_s1_ch1  <= ch1;
        end
    end

    // ---------------- sample assembly ----------------
    always_comb begin
        res0.channel_index = r_s1_ch0;
        res0.last_of_run   = 1'b1;
        res1.channel_index = r_s1_ch1;
        res1.last_of_run   = 1'b1;
        res1.sample_value  = $signed({ev_b, od_b, r_s1_byte[3:0], 4'h0});
        case (r_s1_kind)
            KIND_S16: res0.sample_value = $signed({ev_a, r_s1_byte, 8'h00});
            KIND_S24: res0.sample_value = $signed({ev_a, od_a, r_s1_byte});
            KIND_S20: begin
                res0.sample_value = $signed({ev_a, od_a, r_s1_byte[7:4], 4'h0});
                res0.last_of_run  = 1'b0;
            end
            default:  res0.sample_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_two <= 1'b0;
        end else if (s1_adv && r_s1_kind != KIND_NONE) begin
            r_ov  <= 1'b1;
            r_two <= (r_s1_kind == KIND_S20);
        end else if (r_ov && i_out_ready) begin
            if (r_two) begin
                r_two <= 1'b0;
            end else begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_kind != KIND_NONE) begin
            r_o0 <= res0;
            r_o1 <= res1;
        end else if (r_ov && i_out_ready && r_two) begin
            r_o0 <= r_o1;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_item  = r_o0;

endmodule

`default_nettype wire

>>> sv/lpcm_su_ram.sv
// ----------------------------------------------------------------------------
// lpcm_su_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcm_su_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

>>> bench/lpcm_sample_unpacker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lpcm_sample_unpacker_test
// Checks the LPCM unpacker against a cycle-free prediction of its samples.
// Short directed runs cover each width mode, full-scale samples and frame
// realignment. Then random chunks follow, mostly well formed and some cut
// short or broken, under random register settings and random stalls.
// ----------------------------------------------------------------------------

module lpcm_sample_unpacker_test;

    import lpcm_su_pkg::*;

    localparam int STORE_DEPTH   = 4 * MAX_CHANNELS_DEF;
    localparam int TARGET_BYTES  = 660;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 400000;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in                   i_in_item   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out                  o_out_item;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // mirror of the block state used for prediction
    logic [7:0]  msb_bytes [STORE_DEPTH];
    int          chunk_pos  = 0;
    t_width_mode width_mode = MODE_16;
    logic [2:0]  chan_m1    = 3'd1;

    t_out expected_samples [$];

    int error_count   = 0;
    int bytes_sent    = 0;
    int samples_seen  = 0;
    int settings_used = 0;
    int cycle_count   = 0;
    int sink_hold     = 0;
    bit no_idle       = 1'b0;

    lpcm_sample_unpacker DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold   <= sink_hold - 1;
            i_out_ready <= 1'b0;
        end else begin
            sink_hold   <= pick_gap();
            i_out_ready <= 1'b1;
        end
    end

    function automatic logic [23:0] high_bytes(input int k);
        int i;
        i = (2 * k) % STORE_DEPTH;
        return {msb_bytes[i], msb_bytes[i + 1], 8'h00};
    endfunction

    function automatic void expect_sample(input logic [23:0] value, input int ch,
                                          input logic last);
        t_out s;
        s.sample_value  = value;
        s.channel_index = 3'(ch);
        s.last_of_run   = last;
        expected_samples.push_back(s);
    endfunction

    function automatic void predict_samples(input t_in item);
        int n, len, p, j;
        n = int'(chan_m1) + 1;
        case (width_mode)
            MODE_20: len = 5 * n;
            MODE_24: len = 6 * n;
            default: len = 2 * n;
        endcase
        if (item.frame_start || chunk_pos >= len)
            chunk_pos = 0;
        p = chunk_pos;
        chunk_pos = (p + 1 >= len) ? 0 : p + 1;

        if (width_mode == MODE_16 || width_mode == MODE_16B) begin
            if (p % 2 == 0)
                msb_bytes[0] = item.data_byte;
            else
                expect_sample({msb_bytes[0], item.data_byte, 8'h00}, p / 2, 1'b1);
        end else if (p < 4 * n) begin
            msb_bytes[p % STORE_DEPTH] = item.data_byte;
        end else begin
            j = p - 4 * n;
            if (width_mode == MODE_24) begin
                expect_sample(high_bytes(j) | {16'h0, item.data_byte}, j % n, 1'b1);
            end else begin
                // 20 bit: high nibble completes the even sample, low nibble the odd one
                expect_sample(high_bytes(2 * j) | {16'h0, item.data_byte[7:4], 4'h0},
                              (2 * j) % n, 1'b0);
                expect_sample(high_bytes(2 * j + 1) | {16'h0, item.data_byte[3:0], 4'h0},
                              (2 * j + 1) % n, 1'b1);
            end
        end
    endfunction

    always @(posedge i_clk) begin : check_samples
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            samples_seen++;
            if (expected_samples.size() == 0) begin
                $error("unexpected sample transaction: value %h, channel %0d",
                       o_out_item.sample_value, o_out_item.channel_index);
                error_count++;
            end else begin
                want = expected_samples.pop_front();
                if (o_out_item.sample_value !== want.sample_value) begin
                    $error("sample_value: expected %h, got %h",
                           want.sample_value, o_out_item.sample_value);
                    error_count++;
                end
                if (o_out_item.channel_index !== want.channel_index) begin
                    $error("channel_index: expected %0d, got %0d",
                           want.channel_index, o_out_item.channel_index);
                    error_count++;
                end
                if (o_out_item.last_of_run !== want.last_of_run) begin
                    $error("last_of_run: expected %0d, got %0d",
                           want.last_of_run, o_out_item.last_of_run);
                    error_count++;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic fs);
        int gap;
        t_in item;
        gap = pick_gap();
        item.data_byte   = value;
        item.frame_start = fs;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_samples(item);
        bytes_sent++;
    endtask

    // wait for every pending sample, then for the pipeline to empty
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write one register, then read it back
    task automatic set_register(input logic index, input logic [31:0] value);
        logic [31:0] mask;
        mask = (index == REG_WIDTH_MODE) ? 32'h3 : 32'h7;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (index)
            REG_WIDTH_MODE: width_mode = t_width_mode'(value[1:0]);
            REG_CHAN_M1:    chan_m1    = value[2:0];
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if ((prdata & mask) !== (value & mask)) begin
            $error("prdata: expected %h, got %h", value & mask, prdata & mask);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input t_width_mode mode, input int cm1);
        settle();
        set_register(REG_WIDTH_MODE, 32'(mode));
        set_register(REG_CHAN_M1, 32'(cm1));
        settings_used++;
    endtask

    // reset settings: 16 bit, two channels, full-scale extremes
    task automatic test_reset_defaults();
        send_byte(8'h80, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
    endtask

    task automatic test_alt_16bit_code();
        configure(MODE_16B, 0);
        send_byte(8'h12, 1'b1);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h78, 1'b0);
    endtask

    // frame start halfway through a pair drops the pending high byte
    task automatic test_frame_realign();
        configure(MODE_16, 1);
        send_byte(8'hAB, 1'b1);
        send_byte(8'hCD, 1'b1);
        send_byte(8'hEF, 1'b0);
    endtask

    task automatic test_20bit_chunk();
        configure(MODE_20, 0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b0);
    endtask

    task automatic test_24bit_chunk();
        configure(MODE_24, 0);
        send_byte(8'h80, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b0);
    endtask

    // eight channels fill the whole high-byte buffer
    task automatic test_eight_channel_chunks();
        configure(MODE_24, 7);
        for (int i = 0; i < 48; i++) send_byte(8'($urandom), i == 0);
        configure(MODE_20, 7);
        for (int i = 0; i < 40; i++) send_byte(8'($urandom), i == 0);
    endtask

    // shrink the chunk under a position that no longer fits
    task automatic test_position_past_chunk();
        configure(MODE_20, 1);
        for (int i = 0; i < 7; i++) send_byte(8'($urandom), i == 0);
        configure(MODE_16, 0);
        for (int i = 0; i < 4; i++) send_byte(8'($urandom), 1'b0);
    endtask

    task automatic run_random_phase();
        int pick, cm1, len, chunks, cut;
        bit carry_on;
        logic fs;
        t_width_mode mode;
        mode = t_width_mode'($urandom_range(0, 3));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            cm1 = 0;
        else if (pick == 1)
            cm1 = 7;
        else
            cm1 = $urandom_range(0, 7);
        configure(mode, cm1);
        case (mode)
            MODE_20: len = 5 * (cm1 + 1);
            MODE_24: len = 6 * (cm1 + 1);
            default: len = 2 * (cm1 + 1);
        endcase
        no_idle  = ($urandom_range(0, 5) == 0);
        carry_on = ($urandom_range(0, 3) == 0);
        chunks   = $urandom_range(1, 3);
        for (int c = 0; c < chunks; c++) begin
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : len;
            for (int i = 0; i < cut; i++) begin
                if (i == 0)
                    fs = (c == 0) ? !carry_on : ($urandom_range(0, 4) != 0);
                else
                    fs = ($urandom_range(0, 49) == 0);
                send_byte(8'($urandom), fs);
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        while (bytes_sent < TARGET_BYTES) run_random_phase();
    endtask

    initial begin
        foreach (msb_bytes[i]) msb_bytes[i] = 8'h00;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_alt_16bit_code();
        test_frame_realign();
        test_20bit_chunk();
        test_24bit_chunk();
        test_eight_channel_chunks();
        test_position_past_chunk();
        test_random_traffic();
        settle();

        $display("sent %0d payload bytes over %0d register settings", bytes_sent,
                 settings_used);
        $display("compared %0d samples across 16, 20 and 24 bit modes", samples_seen);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
